>>> src/locl_pkg.sv
// Shared types and constants for the loose octree cell locator.
`default_nettype none
package locl_pkg;

    localparam int DEF_MAX_DEPTH  = 8;
    localparam int DEF_COORD_BITS = 32;

    localparam int DEPTH_BITS   = 4;
    localparam int PATH_BITS    = 24;
    localparam int PATH_LEVELS  = PATH_BITS / 3;
    localparam int LIMIT_BITS   = 4;
    localparam int CFG_IDX_BITS = 3;

    // Root bounds after reset: +/-1000.0 in Q16.16
    localparam longint ROOT_MIN_RESET = -64'sd65536000;
    localparam longint ROOT_MAX_RESET = 64'sd65536000;
    localparam int     LIMIT_RESET    = 8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ROOT_MIN_X = 3'd0,
        REG_ROOT_MIN_Y = 3'd1,
        REG_ROOT_MIN_Z = 3'd2,
        REG_ROOT_MAX_X = 3'd3,
        REG_ROOT_MAX_Y = 3'd4,
        REG_ROOT_MAX_Z = 3'd5,
        REG_DEPTH_LIMIT = 3'd6
    } t_cfg_reg;

    // Per-request control that travels down the chain
    typedef struct packed {
        logic valid;
        logic settled;
    } t_ctl;

endpackage
`default_nettype wire

>>> src/locl_root_gate.sv
// Root culling check: decides whether a request may leave the root at all.
`default_nettype none
module locl_root_gate #(
    parameter int COORD_BITS = locl_pkg::DEF_COORD_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic                         i_is_occludee,
    input  wire logic signed [COORD_BITS-1:0] i_bmin [3],
    input  wire logic signed [COORD_BITS-1:0] i_bmax [3],
    input  wire logic signed [COORD_BITS-1:0] i_root_lo [3],
    input  wire logic signed [COORD_BITS-1:0] i_root_hi [3],
    output locl_pkg::t_ctl                    o_ctl,
    output logic signed [COORD_BITS-1:0]      o_bmin [3],
    output logic signed [COORD_BITS-1:0]      o_bmax [3],
    output logic signed [COORD_BITS-1:0]      o_lo [3],
    output logic signed [COORD_BITS-1:0]      o_hi [3]
);
    import locl_pkg::*;

    localparam int W = COORD_BITS + 3;
    localparam int X = W - COORD_BITS;

    logic [2:0] in_cull;
    t_ctl       r_ctl;
    t_ctl       n_ctl;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [W-1:0] bmin_w, bmax_w, lo_w, hi_w, half, clo, chi;
        assign bmin_w = {{X{i_bmin[a][COORD_BITS-1]}}, i_bmin[a]};
        assign bmax_w = {{X{i_bmax[a][COORD_BITS-1]}}, i_bmax[a]};
        assign lo_w   = {{X{i_root_lo[a][COORD_BITS-1]}}, i_root_lo[a]};
        assign hi_w   = {{X{i_root_hi[a][COORD_BITS-1]}}, i_root_hi[a]};
        assign half   = (hi_w - lo_w) >>> 1;
        assign clo    = lo_w - half;
        assign chi    = hi_w + half;
        assign in_cull[a] = (bmin_w >= clo) && (bmin_w <= chi)
                         && (bmax_w >= clo) && (bmax_w <= chi);
    end

    always_comb begin
        n_ctl.valid   = i_valid;
        // Keep at the root unless an occludee fully inside the culling box
        n_ctl.settled = !(i_is_occludee && (&in_cull));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        o_bmin <= i_bmin;
        o_bmax <= i_bmax;
        o_lo   <= i_root_lo;
        o_hi   <= i_root_hi;
    end

    assign o_ctl = r_ctl;

endmodule
`default_nettype wire

>>> src/locl_cell.sv
// One level of the descent: fit test and child selection for a single depth.
`default_nettype none
module locl_cell #(
    parameter int LEVEL      = 0,
    parameter int MAX_DEPTH  = locl_pkg::DEF_MAX_DEPTH,
    parameter int COORD_BITS = locl_pkg::DEF_COORD_BITS,
    parameter int DEPTH_W    = $clog2(MAX_DEPTH + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [DEPTH_W-1:0]            i_limit,
    input  wire locl_pkg::t_ctl                i_ctl,
    input  wire logic [DEPTH_W-1:0]            i_depth,
    input  wire logic [locl_pkg::PATH_BITS-1:0] i_path,
    input  wire logic signed [COORD_BITS-1:0]  i_bmin [3],
    input  wire logic signed [COORD_BITS-1:0]  i_bmax [3],
    input  wire logic signed [COORD_BITS-1:0]  i_lo [3],
    input  wire logic signed [COORD_BITS-1:0]  i_hi [3],
    output locl_pkg::t_ctl                     o_ctl,
    output logic [DEPTH_W-1:0]                 o_depth,
    output logic [locl_pkg::PATH_BITS-1:0]     o_path,
    output logic signed [COORD_BITS-1:0]       o_bmin [3],
    output logic signed [COORD_BITS-1:0]       o_bmax [3],
    output logic signed [COORD_BITS-1:0]       o_lo [3],
    output logic signed [COORD_BITS-1:0]       o_hi [3]
);
    import locl_pkg::*;

    localparam int W = COORD_BITS + 3;
    localparam int X = W - COORD_BITS;

    logic [2:0]                   fit;
    logic [2:0]                   child;
    logic                         stay;
    logic                         active;
    logic                         descend;
    logic signed [COORD_BITS-1:0] cc [3];

    t_ctl                         r_ctl;
    t_ctl                         n_ctl;
    logic [DEPTH_W-1:0]           n_depth;
    logic [PATH_BITS-1:0]         n_path;
    logic signed [COORD_BITS-1:0] n_lo [3];
    logic signed [COORD_BITS-1:0] n_hi [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [W-1:0] bmin_w, bmax_w, lo_w, hi_w, half, quarter, ctr, bctr;
        assign bmin_w  = {{X{i_bmin[a][COORD_BITS-1]}}, i_bmin[a]};
        assign bmax_w  = {{X{i_bmax[a][COORD_BITS-1]}}, i_bmax[a]};
        assign lo_w    = {{X{i_lo[a][COORD_BITS-1]}}, i_lo[a]};
        assign hi_w    = {{X{i_hi[a][COORD_BITS-1]}}, i_hi[a]};
        assign half    = (hi_w - lo_w) >>> 1;
        assign quarter = half >>> 1;
        assign ctr     = (lo_w + hi_w) >>> 1;
        assign bctr    = (bmin_w + bmax_w) >>> 1;
        assign fit[a]  = ((bmax_w - bmin_w) >= half)
                      || (bmin_w <= (lo_w - quarter))
                      || (bmax_w >= (hi_w + quarter));
        assign child[a] = (bctr >= ctr);
        // Center lies between the bounds, so it fits the coordinate width
        assign cc[a]    = ctr[COORD_BITS-1:0];
        assign n_lo[a]  = (descend && child[a])  ? cc[a] : i_lo[a];
        assign n_hi[a]  = (descend && !child[a]) ? cc[a] : i_hi[a];
    end

    assign active  = i_ctl.valid && !i_ctl.settled;
    assign stay    = (DEPTH_W'(LEVEL) >= i_limit) || (|fit);
    assign descend = active && !stay;

    always_comb begin
        n_ctl.valid   = i_ctl.valid;
        n_ctl.settled = i_ctl.settled || stay;
        n_depth = i_depth;
        n_path  = i_path;
        if (active) begin
            n_depth = stay ? DEPTH_W'(LEVEL) : DEPTH_W'(LEVEL + 1);
        end
        // Levels beyond the path field shift out and drop
        if (descend) begin
            n_path = i_path | (PATH_BITS'(child) << (3 * LEVEL));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        o_depth <= n_depth;
        o_path  <= n_path;
        o_bmin  <= i_bmin;
        o_bmax  <= i_bmax;
        o_lo    <= n_lo;
        o_hi    <= n_hi;
    end

    assign o_ctl = r_ctl;

endmodule
`default_nettype wire

>>> src/loose_octree_cell_locator_core.sv
// Top level of the loose octree cell locator: config registers and the cell chain.
//
// Usage:
//   Request channel: drive the box and the occludee flag with start high; a
//   request is taken at every clock edge where start is high and busy is low.
//   busy stays low, so a new request may be issued on every cycle.
//   Result channel: o_done marks a single cycle in which o_cell_depth and
//   o_cell_path hold the answer for one request, in request order. The
//   receiver cannot stall; results must be captured when o_done is high.
//   Each result passes through the registered root culling stage and then
//   one registered cell per octree level.
//   Throughput: one request per cycle; each cell holds one request per level.
//   Config channel: i_cfg_valid with o_cfg_ready (always high) writes
//   i_cfg_data into the register selected by i_cfg_index (root min x/y/z,
//   root max x/y/z, depth limit); unknown indexes are ignored. Write only
//   while no request is in flight.
//   Reset (synchronous, active low): clears the chain, drops requests in
//   flight, and restores root bounds to +/-1000.0 and the depth limit to 8.
`default_nettype none
module loose_octree_cell_locator_core #(
    parameter int MAX_DEPTH  = locl_pkg::DEF_MAX_DEPTH,
    parameter int COORD_BITS = locl_pkg::DEF_COORD_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic signed [COORD_BITS-1:0]     i_box_min_x,
    input  wire logic signed [COORD_BITS-1:0]     i_box_min_y,
    input  wire logic signed [COORD_BITS-1:0]     i_box_min_z,
    input  wire logic signed [COORD_BITS-1:0]     i_box_max_x,
    input  wire logic signed [COORD_BITS-1:0]     i_box_max_y,
    input  wire logic signed [COORD_BITS-1:0]     i_box_max_z,
    input  wire logic                             i_is_occludee,
    output logic                                  o_done,
    output logic [locl_pkg::DEPTH_BITS-1:0]       o_cell_depth,
    output logic [locl_pkg::PATH_BITS-1:0]        o_cell_path,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [locl_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [COORD_BITS-1:0]            i_cfg_data
);
    import locl_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int LAT     = MAX_DEPTH + 1;

    logic signed [COORD_BITS-1:0] r_root_lo [3];
    logic signed [COORD_BITS-1:0] r_root_hi [3];
    logic [LIMIT_BITS-1:0]        r_depth_limit;
    logic [DEPTH_W-1:0]           limit_eff;
    logic                         cfg_wr;
    logic                         req_acc;

    logic signed [COORD_BITS-1:0] box_min [3];
    logic signed [COORD_BITS-1:0] box_max [3];

    t_ctl                         s_ctl   [MAX_DEPTH+1];
    logic [DEPTH_W-1:0]           s_depth [MAX_DEPTH+1];
    logic [PATH_BITS-1:0]         s_path  [MAX_DEPTH+1];
    logic signed [COORD_BITS-1:0] s_bmin  [MAX_DEPTH+1][3];
    logic signed [COORD_BITS-1:0] s_bmax  [MAX_DEPTH+1][3];
    logic signed [COORD_BITS-1:0] s_lo    [MAX_DEPTH+1][3];
    logic signed [COORD_BITS-1:0] s_hi    [MAX_DEPTH+1][3];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign req_acc     = start && !busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_root_lo[a] <= COORD_BITS'(ROOT_MIN_RESET);
                r_root_hi[a] <= COORD_BITS'(ROOT_MAX_RESET);
            end
            r_depth_limit <= LIMIT_BITS'(LIMIT_RESET);
        end else if (cfg_wr) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_ROOT_MIN_X:  r_root_lo[0]  <= i_cfg_data;
                REG_ROOT_MIN_Y:  r_root_lo[1]  <= i_cfg_data;
                REG_ROOT_MIN_Z:  r_root_lo[2]  <= i_cfg_data;
                REG_ROOT_MAX_X:  r_root_hi[0]  <= i_cfg_data;
                REG_ROOT_MAX_Y:  r_root_hi[1]  <= i_cfg_data;
                REG_ROOT_MAX_Z:  r_root_hi[2]  <= i_cfg_data;
                REG_DEPTH_LIMIT: r_depth_limit <= i_cfg_data[LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the depth limit to one through MAX_DEPTH
    always_comb begin
        if (r_depth_limit == '0) begin
            limit_eff = DEPTH_W'(1);
        end else if ({1'b0, r_depth_limit} > (LIMIT_BITS + 1)'(MAX_DEPTH)) begin
            limit_eff = DEPTH_W'(MAX_DEPTH);
        end else begin
            limit_eff = DEPTH_W'(r_depth_limit);
        end
    end

    assign box_min[0] = i_box_min_x;
    assign box_min[1] = i_box_min_y;
    assign box_min[2] = i_box_min_z;
    assign box_max[0] = i_box_max_x;
    assign box_max[1] = i_box_max_y;
    assign box_max[2] = i_box_max_z;

    locl_root_gate #(
        .COORD_BITS(COORD_BITS)
    ) u_root_gate (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (req_acc),
        .i_is_occludee (i_is_occludee),
        .i_bmin        (box_min),
        .i_bmax        (box_max),
        .i_root_lo     (r_root_lo),
        .i_root_hi     (r_root_hi),
        .o_ctl         (s_ctl[0]),
        .o_bmin        (s_bmin[0]),
        .o_bmax        (s_bmax[0]),
        .o_lo          (s_lo[0]),
        .o_hi          (s_hi[0])
    );

    assign s_depth[0] = '0;
    assign s_path[0]  = '0;

    for (genvar k = 0; k < MAX_DEPTH; k++) begin : g_cell
        locl_cell #(
            .LEVEL      (k),
            .MAX_DEPTH  (MAX_DEPTH),
            .COORD_BITS (COORD_BITS),
            .DEPTH_W    (DEPTH_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_limit (limit_eff),
            .i_ctl   (s_ctl[k]),
            .i_depth (s_depth[k]),
            .i_path  (s_path[k]),
            .i_bmin  (s_bmin[k]),
            .i_bmax  (s_bmax[k]),
            .i_lo    (s_lo[k]),
            .i_hi    (s_hi[k]),
            .o_ctl   (s_ctl[k+1]),
            .o_depth (s_depth[k+1]),
            .o_path  (s_path[k+1]),
            .o_bmin  (s_bmin[k+1]),
            .o_bmax  (s_bmax[k+1]),
            .o_lo    (s_lo[k+1]),
            .o_hi    (s_hi[k+1])
        );
    end

    assign o_done       = s_ctl[MAX_DEPTH].valid;
    assign o_cell_depth = DEPTH_BITS'(s_depth[MAX_DEPTH]);
    assign o_cell_path  = s_path[MAX_DEPTH];

    // Every request yields its result after the full chain
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |-> ##LAT o_done)
        else $error("result strobe missing after chain latency");

    // A non-occludee never leaves the root
    a_root_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && !i_is_occludee) |-> ##LAT (o_cell_depth == '0 && o_cell_path == '0))
        else $error("non-occludee placed below the root");

    // Path bits above the reported depth stay clear
    a_path_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (int'(s_depth[MAX_DEPTH]) < PATH_LEVELS))
            |-> ((o_cell_path >> (3 * int'(s_depth[MAX_DEPTH]))) == '0))
        else $error("path holds bits beyond the cell depth");

endmodule
`default_nettype wire
